// File: rtl/core/signed_angle_between_vectors_top_defines.svh
// Assertion macros for the signed angle block checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SIGNED_ANGLE_BETWEEN_VECTORS_TOP_DEFINES_SVH
`define SIGNED_ANGLE_BETWEEN_VECTORS_TOP_DEFINES_SVH

// Same-cycle implication, checked at every edge outside reset.
`define SABV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("signed angle check failed");

// Next-cycle implication, checked at every edge outside reset.
`define SABV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("signed angle check failed");

`endif

// File: rtl/core/sabv_pkg.sv
// Shared types, widths and constants for the signed angle block.
// The arctangent table is built at elaboration; no dependencies.
`default_nettype none

package sabv_pkg;

  localparam int COMP_W       = 16;
  localparam int ANGLE_FRAC   = 13;
  localparam int ANGLE_W      = ANGLE_FRAC + 3;
  localparam int MAG_W        = COMP_W + 1;
  localparam int SCALE_EXP    = 14;             // scaled max magnitude in [2^14, 2^15]
  localparam int SC_W         = SCALE_EXP + 3;  // signed scaled component
  localparam int PROD_W       = 2 * SC_W;
  localparam int DOT_W        = PROD_W + 2;
  localparam int SQ_W         = 64;
  localparam int ROOT_W       = SQ_W / 2;
  localparam int REM_W        = ROOT_W + 4;
  localparam int PRESCALE     = 20;
  localparam int XW           = DOT_W + PRESCALE;
  localparam int ZW           = 64;
  localparam int CORDIC_STEPS = 48;
  localparam int TAB_FRAC     = 60;
  localparam int ROUND_SHIFT  = TAB_FRAC - ANGLE_FRAC;
  localparam int PREP_STAGES  = 7;
  localparam int LATENCY      = PREP_STAGES + ROOT_W + CORDIC_STEPS + 2;

  typedef struct packed {
    logic signed [COMP_W-1:0] first_x;
    logic signed [COMP_W-1:0] first_y;
    logic signed [COMP_W-1:0] first_z;
    logic signed [COMP_W-1:0] second_x;
    logic signed [COMP_W-1:0] second_y;
    logic signed [COMP_W-1:0] second_z;
  } sabv_in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] signed_angle;
    logic                      degenerate;
  } sabv_out_t;

  typedef struct packed {
    logic neg;
    logic degen;
  } sabv_flags_t;

  typedef struct packed {
    sabv_flags_t              flags;
    logic signed [DOT_W-1:0]  dot;
  } sabv_side_t;

  typedef logic [ZW-1:0] atan_tab_t [CORDIC_STEPS];

  // unsigned quotient by shift and subtract, used only while building the table
  function automatic logic [ZW-1:0] udiv(input logic [ZW-1:0] num,
                                         input logic [ZW-1:0] den);
    logic [ZW-1:0] q;
    logic [ZW:0]   rem;
    q   = '0;
    rem = '0;
    for (int b = ZW - 1; b >= 0; b--) begin
      rem = {rem[ZW-1:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q60, truncated alternating series
  function automatic logic [ZW-1:0] atan_inv(input logic [ZW-1:0] n);
    logic [ZW-1:0] t;
    logic [ZW-1:0] sum;
    logic [ZW-1:0] k;
    t   = udiv(ZW'(1) << TAB_FRAC, n);
    sum = '0;
    k   = '0;
    while (t != '0) begin
      if (k[0] == 1'b0) begin
        sum = sum + udiv(t, ZW'(2) * k + ZW'(1));
      end else begin
        sum = sum - udiv(t, ZW'(2) * k + ZW'(1));
      end
      t = udiv(t, n * n);
      k = k + ZW'(1);
    end
    return sum;
  endfunction

  // atan(2^-i) in Q60; Machin's formula for i = 0
  function automatic logic [ZW-1:0] atan_pow2(input int i);
    logic [ZW-1:0] sum;
    int            e;
    sum = '0;
    if (i == 0) begin
      sum = ZW'(4) * atan_inv(ZW'(5)) - atan_inv(ZW'(239));
    end else begin
      for (int k = 0; k < TAB_FRAC; k++) begin
        e = i * (2 * k + 1);
        if (e <= TAB_FRAC) begin
          if ((k & 1) == 0) begin
            sum = sum + udiv(ZW'(1) << (TAB_FRAC - e), ZW'(2 * k + 1));
          end else begin
            sum = sum - udiv(ZW'(1) << (TAB_FRAC - e), ZW'(2 * k + 1));
          end
        end
      end
    end
    return sum;
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      tab[i] = atan_pow2(i);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  localparam logic [ZW-1:0] PI_Q       = ATAN_TAB[0] << 2;
  localparam logic [ZW-1:0] HALF_PI_Q  = ATAN_TAB[0] << 1;
  localparam logic [ZW-1:0] ROUND_HALF = ZW'(1) << (ROUND_SHIFT - 1);
  localparam logic [ZW-1:0] PI_R       = (PI_Q + ROUND_HALF) >> ROUND_SHIFT;
  localparam logic [ZW-1:0] HALF_PI_R  = (HALF_PI_Q + ROUND_HALF) >> ROUND_SHIFT;

  localparam logic signed [ANGLE_W-1:0] ANGLE_PI      = ANGLE_W'(PI_R);
  localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = ANGLE_W'(HALF_PI_R);

endpackage

`default_nettype wire

// File: rtl/core/sabv_prep.sv
// Front end: block scaling, dot and cross products, squared cross length.
// Seven register stages; uses sabv_pkg.
`default_nettype none

module sabv_prep (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  input  sabv_pkg::sabv_in_t       operands,
  output logic                     out_valid,
  output logic [sabv_pkg::SQ_W-1:0] sq,
  output sabv_pkg::sabv_side_t     side
);
  import sabv_pkg::*;

  // power-of-two scaling of one magnitude against the vector's largest one
  function automatic logic [SC_W-2:0] scale_mag(input logic [MAG_W-1:0] mag,
                                                input logic [MAG_W-1:0] big);
    logic [MAG_W+SCALE_EXP-1:0] wide;
    logic [MAG_W-1:0]           top;
    int                         p;
    p = 0;
    for (int b = 0; b < MAG_W; b++) begin
      if (big[b]) p = b;
    end
    wide = {{SCALE_EXP{1'b0}}, mag};
    top  = '0;
    if (p < SCALE_EXP) begin
      wide = wide << (SCALE_EXP - p);
    end else if (p > SCALE_EXP) begin
      top = big >> (p - SCALE_EXP - 1);
      if (top > (MAG_W'(1) << (SCALE_EXP + 1))) begin
        wide = wide >> (p - SCALE_EXP);
      end else begin
        wide = wide >> (p - SCALE_EXP - 1);
      end
    end
    return wide[SC_W-2:0];
  endfunction

  function automatic logic [SQ_W-1:0] sq_of(input logic signed [DOT_W-1:0] v);
    logic [DOT_W-1:0] a;
    a = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
    return SQ_W'(a[ROOT_W-1:0]) * SQ_W'(a[ROOT_W-1:0]);
  endfunction

  logic signed [COMP_W-1:0] comp [6];
  logic signed [MAG_W-1:0]  ext  [6];

  // stage 1: magnitudes, signs, cross z sign products
  logic                       v1;
  logic [MAG_W-1:0]           mag1 [6];
  logic [5:0]                 sgn1;
  logic signed [2*COMP_W-1:0] pa1, pb1;
  // stage 2: largest magnitudes, flags
  logic                       v2;
  logic [MAG_W-1:0]           mag2 [6];
  logic [5:0]                 sgn2;
  logic [MAG_W-1:0]           big_a2, big_b2;
  sabv_flags_t                f2;
  // stage 3: scaled components
  logic                       v3;
  logic signed [SC_W-1:0]     s3 [6];
  sabv_flags_t                f3;
  // stage 4: products
  logic                       v4;
  logic signed [PROD_W-1:0]   p4 [9];
  sabv_flags_t                f4;
  // stage 5: dot and cross
  logic                       v5;
  logic signed [DOT_W-1:0]    dot5;
  logic signed [DOT_W-1:0]    c5 [3];
  sabv_flags_t                f5;
  // stage 6: squares
  logic                       v6;
  logic signed [DOT_W-1:0]    dot6;
  logic [SQ_W-1:0]            q6 [3];
  sabv_flags_t                f6;

  logic [MAG_W-1:0] big_a_next, big_b_next;

  always_comb begin
    comp[0] = operands.first_x;
    comp[1] = operands.first_y;
    comp[2] = operands.first_z;
    comp[3] = operands.second_x;
    comp[4] = operands.second_y;
    comp[5] = operands.second_z;
    for (int j = 0; j < 6; j++) begin
      ext[j] = MAG_W'(comp[j]);
    end
  end

  always_comb begin
    big_a_next = mag1[0];
    if (mag1[1] > big_a_next) big_a_next = mag1[1];
    if (mag1[2] > big_a_next) big_a_next = mag1[2];
    big_b_next = mag1[3];
    if (mag1[4] > big_b_next) big_b_next = mag1[4];
    if (mag1[5] > big_b_next) big_b_next = mag1[5];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 6; j++) begin
      mag1[j] <= ext[j][MAG_W-1] ? MAG_W'(-ext[j]) : MAG_W'(ext[j]);
      sgn1[j] <= comp[j][COMP_W-1];
    end
    pa1 <= operands.first_x * operands.second_y;
    pb1 <= operands.first_y * operands.second_x;

    mag2      <= mag1;
    sgn2      <= sgn1;
    big_a2    <= big_a_next;
    big_b2    <= big_b_next;
    f2.degen  <= (big_a_next == '0) || (big_b_next == '0);
    f2.neg    <= (pa1 < pb1);

    for (int j = 0; j < 6; j++) begin
      if (sgn2[j]) begin
        s3[j] <= -$signed({1'b0, scale_mag(mag2[j], (j < 3) ? big_a2 : big_b2)});
      end else begin
        s3[j] <= $signed({1'b0, scale_mag(mag2[j], (j < 3) ? big_a2 : big_b2)});
      end
    end
    f3 <= f2;

    p4[0] <= s3[0] * s3[3];
    p4[1] <= s3[1] * s3[4];
    p4[2] <= s3[2] * s3[5];
    p4[3] <= s3[1] * s3[5];
    p4[4] <= s3[2] * s3[4];
    p4[5] <= s3[2] * s3[3];
    p4[6] <= s3[0] * s3[5];
    p4[7] <= s3[0] * s3[4];
    p4[8] <= s3[1] * s3[3];
    f4    <= f3;

    dot5  <= DOT_W'(p4[0]) + DOT_W'(p4[1]) + DOT_W'(p4[2]);
    c5[0] <= DOT_W'(p4[3]) - DOT_W'(p4[4]);
    c5[1] <= DOT_W'(p4[5]) - DOT_W'(p4[6]);
    c5[2] <= DOT_W'(p4[7]) - DOT_W'(p4[8]);
    f5    <= f4;

    dot6  <= dot5;
    for (int k = 0; k < 3; k++) begin
      q6[k] <= sq_of(c5[k]);
    end
    f6    <= f5;

    sq         <= q6[0] + q6[1] + q6[2];
    side.dot   <= dot6;
    side.flags <= f6;
  end

endmodule

`default_nettype wire

// File: rtl/core/sabv_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries the item's side data along; uses sabv_pkg.
`default_nettype none

module sabv_isqrt (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  wire [sabv_pkg::SQ_W-1:0]     sq,
  input  sabv_pkg::sabv_side_t         side_in,
  output logic                         out_valid,
  output logic [sabv_pkg::ROOT_W-1:0]  root,
  output sabv_pkg::sabv_side_t         side_out
);
  import sabv_pkg::*;

  logic              v_q   [ROOT_W];
  logic [SQ_W-1:0]   n_q   [ROOT_W];
  logic [REM_W-1:0]  rem_q [ROOT_W];
  logic [ROOT_W-1:0] r_q   [ROOT_W];
  sabv_side_t        s_q   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    logic              v_in;
    logic [SQ_W-1:0]   n_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] r_in;
    sabv_side_t        s_in;
    logic [REM_W-1:0]  cur, trial;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign n_in   = sq;
      assign rem_in = '0;
      assign r_in   = '0;
      assign s_in   = side_in;
    end else begin : g_rest
      assign v_in   = v_q[k-1];
      assign n_in   = n_q[k-1];
      assign rem_in = rem_q[k-1];
      assign r_in   = r_q[k-1];
      assign s_in   = s_q[k-1];
    end

    // bring down the next two radicand bits
    assign cur   = {rem_in[REM_W-3:0], n_in[SQ_W-1-2*k -: 2]};
    assign trial = {2'b00, r_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      n_q[k] <= n_in;
      s_q[k] <= s_in;
      if (cur >= trial) begin
        rem_q[k] <= cur - trial;
        r_q[k]   <= {r_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[k] <= cur;
        r_q[k]   <= {r_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v_q[ROOT_W-1];
  assign root      = r_q[ROOT_W-1];
  assign side_out  = s_q[ROOT_W-1];

endmodule

`default_nettype wire

// File: rtl/core/sabv_cordic.sv
// Vectoring CORDIC: one pre-rotation stage, then one stage per micro-rotation.
// Angle accumulates in Q60; uses sabv_pkg.
`default_nettype none

module sabv_cordic (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  input  wire [sabv_pkg::ROOT_W-1:0]        root,
  input  sabv_pkg::sabv_side_t              side_in,
  output logic                              out_valid,
  output logic signed [sabv_pkg::ZW-1:0]    z,
  output sabv_pkg::sabv_flags_t             flags
);
  import sabv_pkg::*;

  logic signed [XW-1:0] x_init, y_init;

  logic                 pv;
  logic signed [XW-1:0] px, py;
  logic signed [ZW-1:0] pz;
  sabv_flags_t          pf;

  logic                 v_q [CORDIC_STEPS];
  logic signed [XW-1:0] x_q [CORDIC_STEPS];
  logic signed [XW-1:0] y_q [CORDIC_STEPS];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS];
  sabv_flags_t          f_q [CORDIC_STEPS];

  assign x_init = $signed({side_in.dot, {PRESCALE{1'b0}}});
  assign y_init = $signed({{(XW-ROOT_W-PRESCALE){1'b0}}, root, {PRESCALE{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= in_valid;
    end
  end

  // negative dot: rotate by -pi/2 so the vector sits in the right half plane
  always_ff @(posedge clk) begin
    pf <= side_in.flags;
    if (x_init[XW-1]) begin
      px <= y_init;
      py <= -x_init;
      pz <= $signed(HALF_PI_Q);
    end else begin
      px <= x_init;
      py <= y_init;
      pz <= '0;
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_step
    logic                 v_in;
    logic signed [XW-1:0] x_in, y_in, xs, ys;
    logic signed [ZW-1:0] z_in;
    sabv_flags_t          f_in;

    if (j == 0) begin : g_first
      assign v_in = pv;
      assign x_in = px;
      assign y_in = py;
      assign z_in = pz;
      assign f_in = pf;
    end else begin : g_rest
      assign v_in = v_q[j-1];
      assign x_in = x_q[j-1];
      assign y_in = y_q[j-1];
      assign z_in = z_q[j-1];
      assign f_in = f_q[j-1];
    end

    assign xs = x_in >>> j;
    assign ys = y_in >>> j;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    // once y reaches zero the vector is on the axis and stays put
    always_ff @(posedge clk) begin
      f_q[j] <= f_in;
      if (y_in == '0) begin
        x_q[j] <= x_in;
        y_q[j] <= y_in;
        z_q[j] <= z_in;
      end else if (!y_in[XW-1]) begin
        x_q[j] <= x_in + ys;
        y_q[j] <= y_in - xs;
        z_q[j] <= z_in + $signed(ATAN_TAB[j]);
      end else begin
        x_q[j] <= x_in - ys;
        y_q[j] <= y_in + xs;
        z_q[j] <= z_in - $signed(ATAN_TAB[j]);
      end
    end
  end

  assign out_valid = v_q[CORDIC_STEPS-1];
  assign z         = z_q[CORDIC_STEPS-1];
  assign flags     = f_q[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// File: rtl/core/sabv_final.sv
// Output stage: clamp, round to the output format, apply sign and
// the zero-length override. Uses sabv_pkg.
`default_nettype none

module sabv_final (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  input  wire signed [sabv_pkg::ZW-1:0]   z,
  input  sabv_pkg::sabv_flags_t           flags,
  output logic                            done,
  output sabv_pkg::sabv_out_t             result
);
  import sabv_pkg::*;

  logic [ZW-1:0]      zq, r;
  logic [ANGLE_W-1:0] mag;
  sabv_out_t          result_next;

  always_comb begin
    if (z[ZW-1]) begin
      zq = '0;
    end else if ($unsigned(z) > PI_Q) begin
      zq = PI_Q;
    end else begin
      zq = $unsigned(z);
    end
    r = (zq + ROUND_HALF) >> ROUND_SHIFT;
    if (r > PI_R) r = PI_R;
    mag = r[ANGLE_W-1:0];

    if (flags.degen) begin
      result_next.signed_angle = ANGLE_HALF_PI;
      result_next.degenerate   = 1'b1;
    end else begin
      result_next.signed_angle = flags.neg ? $signed(-mag) : $signed(mag);
      result_next.degenerate   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire

// File: rtl/core/signed_angle_between_vectors_top.sv
// Signed angle between two 3D vectors, Q3.13 radians.
// Throughput: one item per cycle, set by the fully pipelined square root
// (32 stages) and CORDIC (49 stages); busy is high only during and just after reset.
// Reset: synchronous, active high; clears all valid bits, no item in flight survives.
// Uses sabv_pkg, sabv_prep, sabv_isqrt, sabv_cordic, sabv_final.
`default_nettype none

module signed_angle_between_vectors_top (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  sabv_pkg::sabv_in_t   operands,
  output logic                 done,
  output sabv_pkg::sabv_out_t  result
);
  import sabv_pkg::*;

  logic              take;
  logic              prep_valid, root_valid, cordic_valid;
  logic [SQ_W-1:0]   sq;
  logic [ROOT_W-1:0] root;
  sabv_side_t        prep_side, root_side;
  logic signed [ZW-1:0] z;
  sabv_flags_t       flags;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign take = start && !busy;

  sabv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (take),
    .operands  (operands),
    .out_valid (prep_valid),
    .sq        (sq),
    .side      (prep_side)
  );

  sabv_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .sq        (sq),
    .side_in   (prep_side),
    .out_valid (root_valid),
    .root      (root),
    .side_out  (root_side)
  );

  sabv_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (root_valid),
    .root      (root),
    .side_in   (root_side),
    .out_valid (cordic_valid),
    .z         (z),
    .flags     (flags)
  );

  sabv_final u_final (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cordic_valid),
    .z        (z),
    .flags    (flags),
    .done     (done),
    .result   (result)
  );

endmodule

`default_nettype wire

// File: rtl/core/sabv_checker.sv
// Port-level checks for the signed angle block, bound to the top level.
// Uses sabv_pkg and the assertion macros header.
`default_nettype none
`include "signed_angle_between_vectors_top_defines.svh"

module sabv_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 start,
  input wire                 busy,
  input sabv_pkg::sabv_in_t  operands,
  input wire                 done,
  input sabv_pkg::sabv_out_t result
);
  import sabv_pkg::*;

  logic zero_first;

  assign zero_first = (operands.first_x == '0) && (operands.first_y == '0) &&
                      (operands.first_z == '0);

  `SABV_ASSERT_NXT(a_busy_clear, !rst, !busy)
  `SABV_ASSERT_IMP(a_done_has_item, done, $past(start && !busy, LATENCY))
  `SABV_ASSERT_IMP(a_degen_angle, done && result.degenerate, result.signed_angle == ANGLE_HALF_PI)
  `SABV_ASSERT_IMP(a_angle_range, done, (result.signed_angle <= ANGLE_PI) && (result.signed_angle >= -ANGLE_PI))
  `SABV_ASSERT_IMP(a_zero_flagged, done && $past(start && !busy && zero_first, LATENCY), result.degenerate)

endmodule

bind signed_angle_between_vectors_top sabv_checker u_sabv_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for signed_angle_between_vectors_top: random and directed vector pairs.
// Expected angles come from an integer CORDIC model kept in this file.
// Depends on sabv_pkg and the top-level RTL.
`timescale 1ns / 100ps

module tb_top;
  import sabv_pkg::*;

  localparam int  NUM_RANDOM  = 1780;
  localparam int  DRAIN_WAIT  = 120;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  STEPS       = 48;
  localparam int  FRAC        = 60;
  localparam int  OUT_FRAC    = 13;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  sabv_in_t  operands = '0;
  logic      done;
  sabv_out_t result;

  sabv_out_t         angle_q[$];
  longint unsigned   atan_q60[STEPS];
  int                mismatches = 0;
  int                cycles = 0;

  signed_angle_between_vectors_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operands(operands), .done(done), .result(result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // atan(1/n) in Q60 by the alternating series
  function automatic longint unsigned arctan_recip(longint unsigned n);
    longint unsigned t, acc, k;
    t = (64'd1 << FRAC) / n;
    acc = 0;
    k = 0;
    while (t != 0) begin
      if (k[0] == 1'b0) acc = acc + t / (2 * k + 1);
      else acc = acc - t / (2 * k + 1);
      t = t / (n * n);
      k++;
    end
    return acc;
  endfunction

  function automatic longint unsigned arctan_pow2(int i);
    longint unsigned acc;
    int e;
    acc = 0;
    if (i == 0) return 4 * arctan_recip(5) - arctan_recip(239);
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > FRAC) break;
      if (k % 2 == 0) acc = acc + (64'd1 << (FRAC - e)) / longint'(2 * k + 1);
      else acc = acc - (64'd1 << (FRAC - e)) / longint'(2 * k + 1);
    end
    return acc;
  endfunction

  // scale so the largest magnitude sits in [2^14, 2^15]; returns 0 for a zero vector
  function automatic bit normalize_vec(input longint v[3], output longint s[3]);
    longint unsigned m[3];
    longint unsigned big, t;
    int ls, rs;
    big = 0; ls = 0; rs = 0;
    for (int j = 0; j < 3; j++) begin
      m[j] = v[j] < 0 ? -v[j] : v[j];
      if (m[j] > big) big = m[j];
    end
    for (int j = 0; j < 3; j++) s[j] = 0;
    if (big == 0) return 1'b0;
    while (big < 16384) begin big = big << 1; ls++; end
    while (big > 32768) begin big = big >> 1; rs++; end
    for (int j = 0; j < 3; j++) begin
      t = (m[j] << ls) >> rs;
      s[j] = v[j] < 0 ? -longint'(t) : longint'(t);
    end
    return 1'b1;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sq_abs(longint v);
    longint unsigned m;
    m = v < 0 ? -v : v;
    return m * m;
  endfunction

  function automatic sabv_out_t predict_angle(sabv_in_t op);
    longint  va[3], vb[3], sa[3], sb[3];
    longint  d, cx, cy, cz, x, y, z, xs, ys, t;
    longint unsigned c, zq, pi_q, r, pi_r, half;
    bit      neg, degen;
    sabv_out_t res;
    va[0] = op.first_x;  va[1] = op.first_y;  va[2] = op.first_z;
    vb[0] = op.second_x; vb[1] = op.second_y; vb[2] = op.second_z;
    neg = (va[0] * vb[1]) < (va[1] * vb[0]);
    degen = 1'b0;
    if (!normalize_vec(va, sa)) degen = 1'b1;
    if (!normalize_vec(vb, sb)) degen = 1'b1;
    pi_q = 4 * atan_q60[0];
    z = 0;
    if (degen) begin
      neg = 1'b0;
      zq = pi_q / 2;
    end else begin
      d  = sa[0] * sb[0] + sa[1] * sb[1] + sa[2] * sb[2];
      cx = sa[1] * sb[2] - sa[2] * sb[1];
      cy = sa[2] * sb[0] - sa[0] * sb[2];
      cz = sa[0] * sb[1] - sa[1] * sb[0];
      c  = int_sqrt(sq_abs(cx) + sq_abs(cy) + sq_abs(cz));
      x  = d <<< 20;
      y  = longint'(c) <<< 20;
      if (x < 0) begin
        t = x; x = y; y = -t;
        z = longint'(2 * atan_q60[0]);
      end
      for (int i = 0; i < STEPS; i++) begin
        if (y == 0) break;
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + longint'(atan_q60[i]);
        end else begin
          x = x - ys; y = y + xs; z = z - longint'(atan_q60[i]);
        end
      end
      if (z < 0) z = 0;
      zq = z;
      if (zq > pi_q) zq = pi_q;
    end
    half = 64'd1 << (FRAC - OUT_FRAC - 1);
    r    = (zq + half) >> (FRAC - OUT_FRAC);
    pi_r = (pi_q + half) >> (FRAC - OUT_FRAC);
    if (r > pi_r) r = pi_r;
    res.signed_angle = neg ? -ANGLE_W'(r) : ANGLE_W'(r);
    res.degenerate   = degen;
    return res;
  endfunction

  // start stays high across back-to-back items; accepted at the edge where busy is low
  task automatic send_pair(sabv_in_t op);
    @(negedge clk);
    start    <= 1'b1;
    operands <= op;
    do @(posedge clk); while (busy);
    angle_q.push_back(predict_angle(op));
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (n == 0) return;
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_vecs(int ax, int ay, int az, int bx, int by, int bz);
    sabv_in_t op;
    op.first_x  = 16'(ax); op.first_y  = 16'(ay); op.first_z  = 16'(az);
    op.second_x = 16'(bx); op.second_y = 16'(by); op.second_z = 16'(bz);
    send_pair(op);
    idle_gap();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    sabv_out_t want;
    if (!rst && done) begin
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0b",
                                       result.signed_angle, result.degenerate);
      end else begin
        want = angle_q.pop_front();
        if (result.signed_angle !== want.signed_angle ||
            result.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: angle exp %0d got %0d, degenerate exp %0b got %0b",
                     want.signed_angle, result.signed_angle,
                     want.degenerate, result.degenerate);
        end
      end
    end
  end

  function automatic int rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 6)) - 3;
      2: return int'($urandom_range(0, 512)) - 256;
      default: return int'(16'sh0 + $signed(16'($urandom)));
    endcase
  endfunction

  task automatic test_directed();
    send_vecs(0, 0, 0, 0, 0, 0);                 // both zero
    send_vecs(0, 0, 0, 5, -3, 7);                // first zero
    send_vecs(-100, 2, 9, 0, 0, 0);              // second zero
    send_vecs(1, 0, 0, 1, 0, 0);                 // parallel, tiny
    send_vecs(32767, 32767, 32767, 1, 1, 1);     // parallel, scaled
    send_vecs(3, 4, 5, -3, -4, -5);              // antiparallel
    send_vecs(-32768, 0, 0, 32767, 0, 0);        // antiparallel, extremes
    send_vecs(1, 0, 0, 0, 1, 0);                 // +90
    send_vecs(0, 1, 0, 1, 0, 0);                 // -90
    send_vecs(0, 0, 1, 1, 0, 0);                 // cross z zero, 90
    send_vecs(1, 0, 0, -1, 1, 0);                // 135
    send_vecs(1, 0, 0, -1, -1, 0);               // -135
    send_vecs(-32768, -32768, -32768, 32767, -32768, 32767);
    send_vecs(32767, -32768, 0, -32768, 32767, 0);
    send_vecs(-32768, 32767, -1, 32767, 32767, -32768);
    send_vecs(1, 1, 0, 2, 1, 0);                 // small negative-cross angle
    send_vecs(32767, 1, 0, 32767, 0, 0);         // near-parallel
    send_vecs(-32768, 1, 0, 32767, 0, 0);        // near-antiparallel
    send_vecs(0, 0, -32768, 0, 0, 32767);
    send_vecs(-1, -1, -1, -1, -1, -1);
  endtask

  task automatic test_random_pairs(int count);
    for (int i = 0; i < count; i++)
      send_vecs(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  // b is a copy of a or its negation with a little noise: angles near 0 and pi
  task automatic test_near_aligned(int count);
    int ax, ay, az, k;
    for (int i = 0; i < count; i++) begin
      ax = int'($signed(16'($urandom))) / 4;
      ay = int'($signed(16'($urandom))) / 4;
      az = int'($signed(16'($urandom))) / 4;
      k  = $urandom_range(0, 1) ? 1 : -1;
      send_vecs(ax, ay, az, k * ax + int'($urandom_range(0, 6)) - 3,
                k * ay + int'($urandom_range(0, 6)) - 3, k * az);
    end
  endtask

  initial begin
    for (int i = 0; i < STEPS; i++) atan_q60[i] = arctan_pow2(i);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_random_pairs(NUM_RANDOM / 2);
    wait_drained();
    test_near_aligned(NUM_RANDOM / 4);
    test_random_pairs(NUM_RANDOM / 4);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && angle_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
